>>> hw/rtl/bbce_pkg.sv
// Shared types, constants and the palette function of the bitmap byte color expander.
// Used by bbce_ctrl, bbce_datapath and bitmap_byte_color_expander.
package bbce_pkg;

  localparam int PROM_DEPTH  = 2048;
  localparam int PROM_AW     = $clog2(PROM_DEPTH);
  localparam int ROW_BYTES   = 32;
  localparam int LOOKUP_W    = 11;
  localparam int LATCH_COUNT = 3;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 48;

  typedef enum logic [1:0] {
    KIND_VIDEO = 2'd0,
    KIND_LATCH = 2'd1,
    KIND_PROM  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    VAR_TALL_A = 2'd0,
    VAR_TALL_B = 2'd1,
    VAR_SQUARE = 2'd2,
    VAR_WIDE   = 2'd3
  } variant_t;

  typedef enum logic {
    CFG_VARIANT = 1'b0,
    CFG_FLIP    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic latch_wr;
    logic prom_wr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_pix;
  } status_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t palette(variant_t variant, logic [3:0] i);
    rgb_t c;
    c.red   = i[0] ? 8'hff : 8'h00;
    c.green = i[1] ? 8'hff : 8'h00;
    c.blue  = i[2] ? 8'hff : 8'h00;
    unique case (variant)
      VAR_TALL_A: begin
        if ((i & 4'h0c) == 4'h08) c.blue = 8'haa;
      end
      VAR_TALL_B: begin
      end
      VAR_SQUARE: begin
        c.red   = (i > 4'd8) ? 8'hff : (i[0] ? 8'haa : 8'h00);
        c.green = i[1] ? 8'haa : 8'h00;
        c.blue  = i[2] ? 8'haa : 8'h00;
      end
      VAR_WIDE: begin
        if ((i & 4'h09) == 4'h08) c.red = 8'haa;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/bbce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module bbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/bbce_ctrl.sv
// Controller of the expander: accepts items, sequences the eight pixels of a byte
// and owns the output valid flag. Depends on bbce_pkg.
module bbce_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bbce_pkg::cmd_t    cmd,
  input  bbce_pkg::status_t status
);

  bbce_pkg::state_t state, state_next;
  logic out_valid_next;
  logic load_out;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bbce_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    load_out     = (state == bbce_pkg::ST_EMIT) && (!out_valid || out_ready);
    in_ready     = (state == bbce_pkg::ST_IDLE) || (load_out && status.last_pix);
    accept       = in_valid && in_ready;
    cmd.capture  = accept && (in_kind == bbce_pkg::KIND_VIDEO);
    cmd.latch_wr = accept && (in_kind == bbce_pkg::KIND_LATCH);
    cmd.prom_wr  = accept && (in_kind == bbce_pkg::KIND_PROM);
    cmd.emit     = load_out;

    state_next = state;
    unique case (state)
      bbce_pkg::ST_IDLE: begin
        if (cmd.capture) state_next = bbce_pkg::ST_EMIT;
      end
      bbce_pkg::ST_EMIT: begin
        if (load_out && status.last_pix && !cmd.capture) state_next = bbce_pkg::ST_IDLE;
      end
      default: state_next = bbce_pkg::ST_IDLE;
    endcase

    priority if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_capture_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == bbce_pkg::ST_EMIT)
    else $error("video item accepted without starting pixel emission");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    state == bbce_pkg::ST_IDLE |-> !cmd.emit)
    else $error("pixel emitted while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.last_pix && !cmd.capture |=> state == bbce_pkg::ST_IDLE)
    else $error("emission did not end after the eighth pixel");

endmodule

>>> hw/rtl/bbce_datapath.sv
// Datapath of the expander: configuration and color latches, PROM lookup,
// pixel counter and the output register. Depends on bbce_pkg and bbce_ram.
module bbce_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_addr,
  input  logic [1:0]                     cfg_wdata,
  input  logic [12:0]                    in_address,
  input  logic [7:0]                     in_data,
  input  bbce_pkg::cmd_t                 cmd,
  output bbce_pkg::status_t              status,
  output logic [bbce_pkg::OUT_DATA_W-1:0] out_data,
  output logic                           out_last
);

  bbce_pkg::variant_t variant;
  logic                         flip;
  logic [bbce_pkg::LATCH_COUNT-1:0] latches;
  logic [7:0]  pix_byte;
  logic [4:0]  col;
  logic [7:0]  row;
  logic        hi_nibble;
  logic        lookup_ok;
  logic [2:0]  pix_cnt;
  logic [7:0]  prom_rdata;
  logic [bbce_pkg::LOOKUP_W-1:0] lookup_idx;
  logic        lookup_in_range;
  logic        prom_in_range;
  logic [7:0]  in_row;
  logic [4:0]  in_col;
  logic [3:0]  lit;
  logic [3:0]  color;
  logic [7:0]  px;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  bbce_pkg::rgb_t rgb;

  always_comb begin
    in_row = in_address[12:5];
    in_col = in_address[4:0];
    unique case (variant)
      bbce_pkg::VAR_SQUARE: lookup_idx = {1'b0, latches[1], latches[0], in_row[7:4], in_col[4:1]};
      bbce_pkg::VAR_WIDE:   lookup_idx = {2'b00, in_col, in_row[7:4]};
      default:              lookup_idx = {latches[2], latches[0], in_col[4:1], in_row[7:3]};
    endcase
    lookup_in_range = 32'(lookup_idx) < 32'(bbce_pkg::PROM_DEPTH);
    prom_in_range   = 32'(in_address) < 32'(bbce_pkg::PROM_DEPTH);
  end

  bbce_ram #(
    .WIDTH(8),
    .DEPTH(bbce_pkg::PROM_DEPTH)
  ) u_prom (
    .clk  (clk),
    .we   (cmd.prom_wr && prom_in_range),
    .waddr(bbce_pkg::PROM_AW'(in_address)),
    .wdata(in_data),
    .re   (cmd.capture),
    .raddr(bbce_pkg::PROM_AW'(lookup_idx)),
    .rdata(prom_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= bbce_pkg::VAR_TALL_A;
      flip    <= 1'b0;
      latches <= '0;
      pix_cnt <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          bbce_pkg::CFG_VARIANT: variant <= bbce_pkg::variant_t'(cfg_wdata);
          bbce_pkg::CFG_FLIP:    flip    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.latch_wr && (in_address < 13'(bbce_pkg::LATCH_COUNT))) begin
        latches[in_address[1:0]] <= (variant == bbce_pkg::VAR_SQUARE) ? in_data[0] : in_data[7];
      end
      priority if (cmd.capture) begin
        pix_cnt <= 3'd0;
      end else if (cmd.emit) begin
        pix_cnt <= pix_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_byte  <= in_data;
      col       <= in_col;
      row       <= in_row;
      hi_nibble <= latches[1] && (variant != bbce_pkg::VAR_SQUARE);
      lookup_ok <= lookup_in_range;
    end
  end

  always_comb begin
    status.last_pix = (pix_cnt == 3'd7);
    if (!lookup_ok) begin
      lit = 4'd0;
    end else begin
      lit = hi_nibble ? prom_rdata[7:4] : prom_rdata[3:0];
    end
    color = pix_byte[3'd7 - pix_cnt] ? lit : 4'd0;
    rgb   = bbce_pkg::palette(variant, color);
    px    = {col, pix_cnt};
    out_x = flip ? ~px : px;
    out_y = flip ? ~row : row;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {4'd0, rgb.blue, rgb.green, rgb.red, color, out_y, out_x};
      out_last <= status.last_pix;
    end
  end

  a_capture_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> pix_cnt == 3'd0)
    else $error("pixel counter not cleared on a new video item");

  a_emit_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !cmd.capture |=> pix_cnt == 3'($past(pix_cnt) + 3'd1))
    else $error("pixel counter did not advance on emission");

endmodule

>>> hw/rtl/bitmap_byte_color_expander.sv
// Top level of the bitmap byte color expander: controller, datapath and PROM.
// Depends on bbce_pkg, bbce_ctrl, bbce_datapath and bbce_ram.
// A video write sets the controller to its emit state; its first pixel is then loaded
// into the single output register once that is free, then one pixel per cycle while the
// receiver is ready; latch writes and PROM loads yield no items.
// Reset clears control state, configuration and color latches; the PROM is not cleared.
module bitmap_byte_color_expander (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_addr,
  input  logic [1:0]                      cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bbce_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // address[12:0], data[20:13], zero fill
  input  logic [1:0]                      s_axis_tuser,  // kind[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bbce_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // pixel_x, pixel_y, color_index, red, green, blue
  output logic                            m_axis_tlast
);

  bbce_pkg::cmd_t    cmd;
  bbce_pkg::status_t status;

  bbce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  bbce_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_address(s_axis_tdata[12:0]),
    .in_data   (s_axis_tdata[20:13]),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

>>> tb/tb_bitmap_byte_color_expander.sv
// Self-checking testbench for bitmap_byte_color_expander: pixel expansion, latches, PROM loads.
// Depends on bbce_pkg and the RTL of the block; stimulus, prediction and checks live here.
module tb_bitmap_byte_color_expander;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int GAP_MAX = 6;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 160;
  localparam int PHASES = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int SHOWN_ERRORS = 10;

  typedef struct {
    logic [1:0]  kind;
    logic [12:0] addr;
    logic [7:0]  data;
  } bus_write_t;

  typedef struct {
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] ci;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'd0;
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  bitmap_byte_color_expander DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Prediction state, advanced as items are accepted.
  bbce_pkg::variant_t cur_variant = bbce_pkg::VAR_TALL_A;
  logic       cur_flip = 1'b0;
  logic [2:0] latch_bits = 3'b000;
  logic [7:0] prom_img [bbce_pkg::PROM_DEPTH];

  // Generation state, advanced as items are queued.
  bbce_pkg::variant_t gen_variant = bbce_pkg::VAR_TALL_A;
  logic [2:0] gen_latch = 3'b000;
  bit         gen_written [bbce_pkg::PROM_DEPTH];

  bus_write_t pending_writes[$];
  pixel_t     expected_pixels[$];
  bus_write_t tx_cur;
  pixel_t     exp_px;
  pixel_t     got_px;

  bit tx_busy = 1'b0;
  bit quiet_phase = 1'b0;
  bit long_hold_armed = 1'b0;
  int hold_at = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold = 0;
  int cycle_count = 0;
  int error_count = 0;
  int pixels_checked = 0;
  int video_count = 0;
  int latch_count = 0;
  int load_count = 0;
  int ignored_count = 0;
  int queued_count = 0;

  function automatic int tile_index(bbce_pkg::variant_t v, logic [2:0] lat, int x, int y);
    case (v)
      bbce_pkg::VAR_SQUARE:
        return (int'(lat[0]) << 8) + (int'(lat[1]) << 9) + (y / 16) * 16 + x / 16;
      bbce_pkg::VAR_WIDE:
        return (x / 8) * 16 + y / 16;
      default:
        return (int'(lat[0]) << 9) + (int'(lat[2]) << 10) + (x / 16) * 32 + y / 8;
    endcase
  endfunction

  function automatic logic [3:0] lit_nibble(bbce_pkg::variant_t v, logic [2:0] lat,
                                            logic [7:0] b);
    if (v != bbce_pkg::VAR_SQUARE && lat[1]) return b[7:4];
    return b[3:0];
  endfunction

  function automatic pixel_t shade(bbce_pkg::variant_t v, logic [3:0] c);
    pixel_t p;
    p.ci = c;
    if (v == bbce_pkg::VAR_SQUARE) begin
      p.r = (c > 4'd8) ? 8'hff : ({8{c[0]}} & 8'haa);
      p.g = {8{c[1]}} & 8'haa;
      p.b = {8{c[2]}} & 8'haa;
    end else begin
      p.r = {8{c[0]}};
      p.g = {8{c[1]}};
      p.b = {8{c[2]}};
      if (v == bbce_pkg::VAR_TALL_A && c[3:2] == 2'b10) p.b = 8'haa;
      if (v == bbce_pkg::VAR_WIDE && c[3] && !c[0]) p.r = 8'haa;
    end
    return p;
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("ERROR: %s", msg);
  endfunction

  task automatic expand_byte(bus_write_t it);
    int x;
    int y;
    int idx;
    logic [7:0] prom_byte;
    logic [3:0] lit;
    pixel_t p;
    case (it.kind)
      bbce_pkg::KIND_LATCH: begin
        if (it.addr < bbce_pkg::LATCH_COUNT) begin
          latch_bits[it.addr] = (cur_variant == bbce_pkg::VAR_SQUARE) ? it.data[0]
                                                                       : it.data[7];
          latch_count++;
        end else begin
          ignored_count++;
        end
      end
      bbce_pkg::KIND_PROM: begin
        if (it.addr < bbce_pkg::PROM_DEPTH) begin
          prom_img[it.addr] = it.data;
          load_count++;
        end else begin
          ignored_count++;
        end
      end
      bbce_pkg::KIND_VIDEO: begin
        y = (it.addr / bbce_pkg::ROW_BYTES) % 256;
        x = 8 * (it.addr % bbce_pkg::ROW_BYTES);
        idx = tile_index(cur_variant, latch_bits, x, y);
        prom_byte = (idx < bbce_pkg::PROM_DEPTH) ? prom_img[idx] : 8'h00;
        lit = lit_nibble(cur_variant, latch_bits, prom_byte);
        for (int i = 0; i < 8; i++) begin
          p = shade(cur_variant, it.data[7 - i] ? lit : 4'h0);
          p.x = cur_flip ? 8'(255 - (x + i)) : 8'(x + i);
          p.y = cur_flip ? 8'(255 - y) : 8'(y);
          p.last = (i == 7);
          expected_pixels.push_back(p);
        end
        video_count++;
      end
      default: ignored_count++;
    endcase
  endtask

  task automatic push_write(logic [1:0] kind, int addr, logic [7:0] data);
    bus_write_t it;
    it.kind = kind;
    it.addr = 13'(addr);
    it.data = data;
    if (kind == bbce_pkg::KIND_LATCH && it.addr < bbce_pkg::LATCH_COUNT)
      gen_latch[it.addr] = (gen_variant == bbce_pkg::VAR_SQUARE) ? data[0] : data[7];
    if (kind == bbce_pkg::KIND_PROM && it.addr < bbce_pkg::PROM_DEPTH)
      gen_written[it.addr] = 1'b1;
    pending_writes.push_back(it);
    queued_count++;
  endtask

  // A video write is preceded by a load of its PROM entry if that was never written.
  task automatic push_video(int addr, logic [7:0] data);
    int idx;
    idx = tile_index(gen_variant, gen_latch, 8 * (addr % bbce_pkg::ROW_BYTES),
                     (addr / bbce_pkg::ROW_BYTES) % 256);
    if (!gen_written[idx]) push_write(bbce_pkg::KIND_PROM, idx, 8'($urandom));
    push_write(bbce_pkg::KIND_VIDEO, addr, data);
  endtask

  task automatic push_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      push_video($urandom_range(0, 8191), 8'($urandom));
    end else if (pick < 70) begin
      if ($urandom_range(0, 5) == 0) begin
        push_write(bbce_pkg::KIND_LATCH, $urandom_range(0, 8191), 8'($urandom));
      end else begin
        push_write(bbce_pkg::KIND_LATCH, $urandom_range(0, bbce_pkg::LATCH_COUNT - 1),
                   8'($urandom));
      end
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) == 0) begin
        push_write(bbce_pkg::KIND_PROM, $urandom_range(0, 8191), 8'($urandom));
      end else begin
        push_write(bbce_pkg::KIND_PROM, $urandom_range(0, bbce_pkg::PROM_DEPTH - 1),
                   8'($urandom));
      end
    end else begin
      push_write(KIND_UNUSED, $urandom_range(0, 8191), 8'($urandom));
    end
  endtask

  task automatic set_config(bbce_pkg::cfg_reg_t idx, logic [1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == bbce_pkg::CFG_VARIANT) begin
      cur_variant = bbce_pkg::variant_t'(value);
      gen_variant = bbce_pkg::variant_t'(value);
    end else begin
      cur_flip = value[0];
    end
  endtask

  task automatic wait_idle();
    while (pending_writes.size() != 0 || tx_busy || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding.", cycle_count,
               expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender: one item per handshake, with a random gap between items outside the quiet phases.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!tx_busy) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_writes.size() != 0) begin
        tx_cur = pending_writes.pop_front();
        tx_busy = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, tx_cur.data, tx_cur.addr};
        s_axis_tuser  <= tx_cur.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random gaps after each pixel outside the quiet phases, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_armed && pixels_checked >= hold_at) begin
      long_hold_armed = 1'b0;
      rx_hold = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expand_byte(tx_cur);
      tx_busy = 1'b0;
      tx_gap = quiet_phase ? 0 : $urandom_range(0, GAP_MAX);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_px.x    = m_axis_tdata[7:0];
      got_px.y    = m_axis_tdata[15:8];
      got_px.ci   = m_axis_tdata[19:16];
      got_px.r    = m_axis_tdata[27:20];
      got_px.g    = m_axis_tdata[35:28];
      got_px.b    = m_axis_tdata[43:36];
      got_px.last = m_axis_tlast;
      if (expected_pixels.size() == 0) begin
        note_error($sformatf("unexpected pixel x=%0d y=%0d", got_px.x, got_px.y));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (exp_px.x != got_px.x || exp_px.y != got_px.y || exp_px.ci != got_px.ci ||
            exp_px.r != got_px.r || exp_px.g != got_px.g || exp_px.b != got_px.b ||
            exp_px.last != got_px.last)
          note_error({$sformatf("pixel %0d: expected x=%0d y=%0d c=%0d rgb=%h/%h/%h last=%0b",
                                pixels_checked, exp_px.x, exp_px.y, exp_px.ci, exp_px.r,
                                exp_px.g, exp_px.b, exp_px.last),
                      $sformatf(", got x=%0d y=%0d c=%0d rgb=%h/%h/%h last=%0b",
                                got_px.x, got_px.y, got_px.ci, got_px.r, got_px.g,
                                got_px.b, got_px.last)});
        pixels_checked++;
      end
      rx_gap = quiet_phase ? 0 : $urandom_range(0, GAP_MAX);
    end
  end

  initial begin
    int issued;
    int budget;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      set_config(bbce_pkg::CFG_VARIANT, 2'(p % 4));
      set_config(bbce_pkg::CFG_FLIP, {1'($urandom), 1'(p[0] ^ (p >= 4))});
      quiet_phase = (p == 2 || p == 5);
      if (p == 1) begin
        hold_at = pixels_checked + 40;
        long_hold_armed = 1'b1;
      end
      if (p == 0) begin
        push_write(KIND_UNUSED, 13'h1fff, 8'hff);
        push_write(bbce_pkg::KIND_LATCH, bbce_pkg::LATCH_COUNT, 8'hff);
        push_write(bbce_pkg::KIND_LATCH, 13'h1fff, 8'h80);
        push_write(bbce_pkg::KIND_PROM, bbce_pkg::PROM_DEPTH, 8'h5a);
        push_write(bbce_pkg::KIND_PROM, 13'h1fff, 8'ha5);
        push_video(0, 8'h00);
        push_video(0, 8'hff);
        push_video(13'h1fff, 8'h80);
        push_video(bbce_pkg::ROW_BYTES - 1, 8'h01);
        push_video(8160, 8'haa);
        push_write(bbce_pkg::KIND_PROM, 0, 8'h98);
        push_video(0, 8'hff);
        push_write(bbce_pkg::KIND_PROM, 0, 8'hf7);
        push_write(bbce_pkg::KIND_LATCH, 1, 8'h80);
        push_video(0, 8'hff);
        push_write(bbce_pkg::KIND_LATCH, 0, 8'h80);
        push_write(bbce_pkg::KIND_LATCH, 2, 8'hff);
        push_video(4095, 8'h55);
        push_write(bbce_pkg::KIND_LATCH, 1, 8'h7f);
        push_video(4095, 8'hff);
        push_write(bbce_pkg::KIND_LATCH, 0, 8'h00);
        push_write(bbce_pkg::KIND_LATCH, 2, 8'h7f);
      end
      budget = RANDOM_ITEMS / PHASES;
      issued = queued_count;
      while (queued_count - issued < budget) begin
        push_random();
      end
      wait_idle();
    end

    if (expected_pixels.size() != 0)
      note_error($sformatf("%0d pixels never arrived", expected_pixels.size()));
    $display("Covered %0d video writes (%0d pixels), %0d latch writes, %0d PROM loads,",
             video_count, pixels_checked, latch_count, load_count);
    $display("%0d ignored items, all four variants with both flip settings.", ignored_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
